>>> rtl/pbe_pkg.sv
// Package for the path byte escape encoder: run type, character codes and
// register indexes. No dependencies.
package pbe_pkg;

   // Longest run of output bytes caused by one input item
   localparam int unsigned RUN_MAX = 5;
   localparam int unsigned CNT_W   = 3;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [RUN_MAX-1:0][7:0] bytes;   // left packed, element 0 goes first
      logic [CNT_W-1:0]        cnt;     // number of valid bytes, 0..RUN_MAX
   } run_type;

   typedef struct packed {
      logic escape_mode;
      logic quote_mode;
      logic qmark_mode;
      logic indicator_mode;
   } mode_type;

   typedef enum logic [1:0] {
      CSR_ESCAPE    = 2'd0,
      CSR_QUOTE     = 2'd1,
      CSR_QMARK     = 2'd2,
      CSR_INDICATOR = 2'd3
   } csr_index_type;

   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_END  = 1'b1;

   localparam byte_type CH_BSLASH = 8'h5C;
   localparam byte_type CH_QUOTE  = 8'h22;
   localparam byte_type CH_QMARK  = 8'h3F;
   localparam byte_type CH_COLON  = 8'h3A;
   localparam byte_type CH_STAR   = 8'h2A;
   localparam byte_type CH_ZERO   = 8'h30;
   localparam byte_type CH_SPACE  = 8'h20;
   localparam byte_type CH_TILDE  = 8'h7E;
   localparam byte_type CH_BANG   = 8'h21;

   localparam logic [31:0] TYPE_APPL = 32'h4150_504C;

endpackage

>>> rtl/path_byte_escape_encoder.sv
// Top level of the path byte escape encoder.
// Depends on pbe_pkg and pbe_encoder.
//
// Formats a file name into its displayed text, one output byte per
// transfer on the rsp_ channel. Feed the name bytes with req_action 0, then
// one end item with req_action 1 carrying the directory flag and the
// four-character type code. Each item yields zero to five bytes (an
// opening quote plus a four-byte octal escape at most); rsp_last_of_run
// marks the final byte of an item. Every item is encoded in the cycle it is
// accepted and parked in a one-entry holding register; a separate output
// run register then plays the bytes out, one per cycle while rsp_stall is
// low. The single output byte lane sets the rate: an item producing n bytes
// occupies the output for n transfers, an item with no bytes is dropped, and
// with the output never stalled a new item follows as soon as the previous
// run plays its last byte. Mode registers are sampled when an item is
// accepted, so write them only while the block is idle.
module path_byte_escape_encoder import pbe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_char_byte,
   input  logic        req_is_directory,
   input  logic [31:0] req_file_type,
   // output bytes
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic        csr_wdata
);

   mode_type          mode_ff, mode_in;
   logic              at_start_ff, at_start_in;

   // holding register: one encoded item waiting for the output
   logic              enc_valid_ff, enc_valid_in;
   run_type           enc_run_ff, enc_run_in;

   // output run register
   logic              act_valid_ff, act_valid_in;
   run_type           act_run_ff, act_run_in;
   logic [CNT_W-1:0]  act_idx_ff, act_idx_in;

   run_type           new_run;
   logic              req_xfer, rsp_xfer, act_last, act_free, enc_move;

   pbe_encoder u_encoder (
      .action        (req_action),
      .char_byte     (req_char_byte),
      .is_directory  (req_is_directory),
      .file_type     (req_file_type),
      .mode          (mode_ff),
      .at_name_start (at_start_ff),
      .run           (new_run)
   );

   // Handshake decode
   assign act_last  = (act_idx_ff == act_run_ff.cnt - CNT_W'(1));
   assign rsp_xfer  = act_valid_ff && !rsp_stall;
   assign act_free  = !act_valid_ff || (rsp_xfer && act_last);
   assign enc_move  = enc_valid_ff && act_free;
   assign req_stall = enc_valid_ff && !act_free;
   assign req_xfer  = req_valid && !req_stall;

   assign rsp_valid       = act_valid_ff;
   assign rsp_out_byte    = act_run_ff.bytes[act_idx_ff];
   assign rsp_last_of_run = act_last;

   always_comb begin
      mode_in = mode_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ESCAPE:    mode_in.escape_mode    = csr_wdata;
            CSR_QUOTE:     mode_in.quote_mode     = csr_wdata;
            CSR_QMARK:     mode_in.qmark_mode     = csr_wdata;
            CSR_INDICATOR: mode_in.indicator_mode = csr_wdata;
            default:       mode_in = mode_ff;
         endcase
      end

      // A name byte ends the name start; an end item opens a new name
      at_start_in = req_xfer ? (req_action == ACT_END) : at_start_ff;

      // Holding register: load on transfer, drop items with an empty run
      enc_valid_in = enc_valid_ff;
      enc_run_in   = enc_run_ff;
      if (req_xfer) begin
         enc_valid_in = (new_run.cnt != '0);
         enc_run_in   = new_run;
      end else if (enc_move) begin
         enc_valid_in = 1'b0;
      end

      // Output run: advance on transfer, reload from the holding register, empty after the last byte
      act_valid_in = act_valid_ff;
      act_run_in   = act_run_ff;
      act_idx_in   = act_idx_ff;
      if (enc_move) begin
         act_valid_in = 1'b1;
         act_run_in   = enc_run_ff;
         act_idx_in   = '0;
      end else if (act_free) begin
         act_valid_in = 1'b0;
      end else if (rsp_xfer) begin
         act_idx_in = act_idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= '0;
         at_start_ff  <= 1'b1;
         enc_valid_ff <= 1'b0;
         act_valid_ff <= 1'b0;
         act_idx_ff   <= '0;
      end else begin
         mode_ff      <= mode_in;
         at_start_ff  <= at_start_in;
         enc_valid_ff <= enc_valid_in;
         act_valid_ff <= act_valid_in;
         act_idx_ff   <= act_idx_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      enc_run_ff <= enc_run_in;
      act_run_ff <= act_run_in;
   end

endmodule

>>> rtl/pbe_encoder.sv
// Combinational encoder: turns one input item into its run of output bytes.
// Depends on pbe_pkg.
module pbe_encoder import pbe_pkg::*; (
   input  logic        action,
   input  logic [7:0]  char_byte,
   input  logic        is_directory,
   input  logic [31:0] file_type,
   input  mode_type    mode,
   input  logic        at_name_start,
   output run_type     run
);

   always_comb begin
      byte_type                body [4];
      logic [CNT_W-1:0]        body_cnt;
      byte_type                tail;
      logic                    open_q;
      logic [CNT_W-1:0]        n_quote;
      logic                    ind_on;
      byte_type                ind_ch;
      logic [RUN_MAX-1:0][7:0] bytes;
      logic [CNT_W-1:0]        cnt;

      // Two-character escape tail, zero when the byte has none
      case (char_byte)
         8'h5C:   tail = CH_BSLASH;
         8'h0A:   tail = 8'h6E;   // n
         8'h08:   tail = 8'h62;   // b
         8'h0D:   tail = 8'h72;   // r
         8'h09:   tail = 8'h74;   // t
         8'h0C:   tail = 8'h66;   // f
         8'h20:   tail = CH_SPACE;
         8'h22:   tail = CH_QUOTE;
         default: tail = 8'h00;
      endcase

      body[0]  = char_byte;
      body[1]  = 8'h00;
      body[2]  = 8'h00;
      body[3]  = 8'h00;
      body_cnt = CNT_W'(1);
      if (mode.escape_mode) begin
         if (tail != 8'h00) begin
            body[0]  = CH_BSLASH;
            body[1]  = tail;
            body_cnt = CNT_W'(2);
         end else if (!(char_byte >= CH_BANG && char_byte <= CH_TILDE)) begin
            body[0]  = CH_BSLASH;
            body[1]  = CH_ZERO | {6'd0, char_byte[7:6]};
            body[2]  = CH_ZERO | {5'd0, char_byte[5:3]};
            body[3]  = CH_ZERO | {5'd0, char_byte[2:0]};
            body_cnt = CNT_W'(4);
         end
      end else if (mode.qmark_mode &&
                   !(char_byte >= CH_SPACE && char_byte <= CH_TILDE)) begin
         body[0] = CH_QMARK;
      end

      open_q  = at_name_start && mode.quote_mode;
      n_quote = mode.quote_mode ? (at_name_start ? CNT_W'(2) : CNT_W'(1))
                                : CNT_W'(0);
      ind_on  = mode.indicator_mode && (is_directory || file_type == TYPE_APPL);
      ind_ch  = is_directory ? CH_COLON : CH_STAR;

      bytes = '0;
      if (action == ACT_BYTE) begin
         // Shift the body right by one when the opening quote leads
         for (int i = 0; i < RUN_MAX; i++) begin
            if (open_q) begin
               bytes[i] = (i == 0) ? CH_QUOTE : body[(i + 3) % 4];
            end else begin
               bytes[i] = (i < 4) ? body[i % 4] : 8'h00;
            end
         end
         cnt = body_cnt + CNT_W'(open_q);
      end else begin
         for (int i = 0; i < RUN_MAX; i++) begin
            bytes[i] = (CNT_W'(i) < n_quote) ? CH_QUOTE : ind_ch;
         end
         cnt = n_quote + CNT_W'(ind_on);
      end

      run.bytes = bytes;
      run.cnt   = cnt;
   end

endmodule

>>> rtl/pbe_checker.sv
// Port-level checks for the path byte escape encoder, bound to the top level.
// Depends on path_byte_escape_encoder.
module pbe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   // Hold a stalled result steady
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
                                 && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // The input backs up only behind a pending result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // A run continues after a transfer that is not its last byte
   a_run_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid)
      else $error("run ended without last_of_run");

   // Reset empties both stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

endmodule

bind path_byte_escape_encoder pbe_checker u_pbe_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run)
);
